@@ rtl/btpg_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// btpg_pkg
// Shared types, constants and the 5x7 font for the bitmap text pixel generator.
// ----------------------------------------------------------------------------
package btpg_pkg;

   localparam int GLYPH_ROWS  = 7;
   localparam int GLYPH_COLS  = 5;
   localparam int ROW_W       = $clog2(GLYPH_ROWS);
   localparam int COL_W       = $clog2(GLYPH_COLS);
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   // register indexes on the csr port (byte address is 4 * index)
   localparam logic [1:0] REG_PIXEL_SCALE = 2'd0;
   localparam logic [1:0] REG_ORIGIN_X    = 2'd1;
   localparam logic [1:0] REG_ORIGIN_Y    = 2'd2;
   localparam logic [1:0] REG_CLIP_RIGHT  = 2'd3;

   // rows[0] is the top row, bit GLYPH_COLS-1 of a row is the leftmost column
   typedef logic [GLYPH_ROWS-1:0][GLYPH_COLS-1:0] glyph_type;

   typedef struct packed {
      logic        [5:0]  pixel_scale;
      logic signed [15:0] origin_x;
      logic signed [15:0] origin_y;
      logic signed [15:0] clip_right;
   } cfg_type;

   // one classified character handed from the front to the back
   typedef struct packed {
      glyph_type          rows;
      logic               draw;
      logic signed [15:0] cursor_start;
      logic signed [15:0] cursor_after;
      logic               stopped;
   } job_type;

   function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
      logic signed [15:0] r;
      if (v > 18'sd32767) begin
         r = 16'sh7fff;
      end else if (v < -18'sd32768) begin
         r = 16'sh8000;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

   function automatic glyph_type mk_glyph(input logic [4:0] r0, input logic [4:0] r1,
                                          input logic [4:0] r2, input logic [4:0] r3,
                                          input logic [4:0] r4, input logic [4:0] r5,
                                          input logic [4:0] r6);
      glyph_type g;
      g[0] = r0;
      g[1] = r1;
      g[2] = r2;
      g[3] = r3;
      g[4] = r4;
      g[5] = r5;
      g[6] = r6;
      return g;
   endfunction

   function automatic glyph_type glyph_for(input logic [7:0] code);
      logic [7:0] c;
      glyph_type  g;
      // fold lower case to upper case
      c = (code >= 8'h61 && code <= 8'h7a) ? code - 8'd32 : code;
      unique case (c)
         8'h41:   g = mk_glyph(14, 17, 17, 31, 17, 17, 17);
         8'h42:   g = mk_glyph(30, 17, 17, 30, 17, 17, 30);
         8'h43:   g = mk_glyph(14, 17, 16, 16, 16, 17, 14);
         8'h44:   g = mk_glyph(30, 17, 17, 17, 17, 17, 30);
         8'h45:   g = mk_glyph(31, 16, 16, 30, 16, 16, 31);
         8'h46:   g = mk_glyph(31, 16, 16, 30, 16, 16, 16);
         8'h47:   g = mk_glyph(14, 17, 16, 23, 17, 17, 14);
         8'h48:   g = mk_glyph(17, 17, 17, 31, 17, 17, 17);
         8'h49:   g = mk_glyph(31,  4,  4,  4,  4,  4, 31);
         8'h4a:   g = mk_glyph( 7,  2,  2,  2,  2, 18, 12);
         8'h4b:   g = mk_glyph(17, 18, 20, 24, 20, 18, 17);
         8'h4c:   g = mk_glyph(16, 16, 16, 16, 16, 16, 31);
         8'h4d:   g = mk_glyph(17, 27, 21, 21, 17, 17, 17);
         8'h4e:   g = mk_glyph(17, 25, 21, 19, 17, 17, 17);
         8'h4f:   g = mk_glyph(14, 17, 17, 17, 17, 17, 14);
         8'h50:   g = mk_glyph(30, 17, 17, 30, 16, 16, 16);
         8'h51:   g = mk_glyph(14, 17, 17, 17, 21, 18, 13);
         8'h52:   g = mk_glyph(30, 17, 17, 30, 20, 18, 17);
         8'h53:   g = mk_glyph(15, 16, 16, 14,  1,  1, 30);
         8'h54:   g = mk_glyph(31,  4,  4,  4,  4,  4,  4);
         8'h55:   g = mk_glyph(17, 17, 17, 17, 17, 17, 14);
         8'h56:   g = mk_glyph(17, 17, 17, 17, 17, 10,  4);
         8'h57:   g = mk_glyph(17, 17, 17, 21, 21, 21, 10);
         8'h58:   g = mk_glyph(17, 17, 10,  4, 10, 17, 17);
         8'h59:   g = mk_glyph(17, 17, 10,  4,  4,  4,  4);
         8'h5a:   g = mk_glyph(31,  1,  2,  4,  8, 16, 31);
         8'h30:   g = mk_glyph(14, 17, 19, 21, 25, 17, 14);
         8'h31:   g = mk_glyph( 4, 12,  4,  4,  4,  4, 14);
         8'h32:   g = mk_glyph(14, 17,  1,  2,  4,  8, 31);
         8'h33:   g = mk_glyph(30,  1,  1, 14,  1,  1, 30);
         8'h34:   g = mk_glyph( 2,  6, 10, 18, 31,  2,  2);
         8'h35:   g = mk_glyph(31, 16, 16, 30,  1,  1, 30);
         8'h36:   g = mk_glyph(14, 16, 16, 30, 17, 17, 14);
         8'h37:   g = mk_glyph(31,  1,  2,  4,  8,  8,  8);
         8'h38:   g = mk_glyph(14, 17, 17, 14, 17, 17, 14);
         8'h39:   g = mk_glyph(14, 17, 17, 15,  1,  1, 14);
         8'h3a:   g = mk_glyph( 0, 12, 12,  0, 12, 12,  0);
         8'h2d:   g = mk_glyph( 0,  0,  0, 14,  0,  0,  0);
         8'h20:   g = '0;
         // anything without a glyph draws a question mark
         default: g = mk_glyph(14, 17,  1,  2,  4,  0,  4);
      endcase
      return g;
   endfunction

endpackage
`default_nettype wire

@@ rtl/btpg_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// btpg_front
// Accepts characters, looks up the glyph and advances the cursor and stop flag.
// ----------------------------------------------------------------------------
module btpg_front import btpg_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire cfg_type    cfg,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_char_code,
   input  wire logic       req_string_start,
   input  wire logic       queue_full,
   output logic            push_valid,
   output job_type         push_job
);

   logic signed [15:0] cursor_ff, cursor_in;
   logic               stop_ff, stop_in;

   logic signed [15:0] cur_eff;
   logic               stop_eff;
   logic        [8:0]  step_width;
   logic signed [17:0] cur_sum;
   logic signed [15:0] cur_next;
   logic signed [17:0] clip_lim;
   logic               stop_next;

   assign req_ready  = !queue_full;
   assign push_valid = req_valid && req_ready;

   always_comb begin
      cur_eff    = req_string_start ? cfg.origin_x : cursor_ff;
      stop_eff   = req_string_start ? 1'b0 : stop_ff;
      step_width = 9'(cfg.pixel_scale) * 9'd6;
      cur_sum    = {{2{cur_eff[15]}}, cur_eff} + {9'd0, step_width};
      cur_next   = sat16(cur_sum);
      clip_lim   = {{2{cfg.clip_right[15]}}, cfg.clip_right} - 18'sd8;
      stop_next  = (18'(cur_next) > clip_lim);

      push_job.rows         = glyph_for(req_char_code);
      push_job.draw         = !stop_eff && (cfg.pixel_scale != 6'd0);
      push_job.cursor_start = cur_eff;
      push_job.cursor_after = stop_eff ? cur_eff : cur_next;
      push_job.stopped      = stop_eff ? 1'b1 : stop_next;

      cursor_in = cursor_ff;
      stop_in   = stop_ff;
      if (push_valid) begin
         cursor_in = push_job.cursor_after;
         stop_in   = push_job.stopped;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_ff <= '0;
         stop_ff   <= 1'b0;
      end else begin
         cursor_ff <= cursor_in;
         stop_ff   <= stop_in;
      end
   end

endmodule
`default_nettype wire

@@ rtl/btpg_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// btpg_queue
// Small first-in first-out queue of classified characters.
// ----------------------------------------------------------------------------
module btpg_queue import btpg_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push_valid,
   input  wire job_type push_job,
   input  wire logic    pop,
   output logic         head_valid,
   output job_type      head_job,
   output logic         full
);

   job_type                entry_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]      count_ff, count_in;

   assign head_valid = (count_ff != '0);
   assign full       = (count_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign head_job   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push_valid ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push_valid && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push_valid) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule
`default_nettype wire

@@ rtl/btpg_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// btpg_back
// Walks the lit dots of the head character, one result per cycle while rsp is not stalled, then status.
// ----------------------------------------------------------------------------
module btpg_back import btpg_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire cfg_type cfg,
   input  wire logic    head_valid,
   input  wire job_type head_job,
   output logic         pop,
   output logic                rsp_valid,
   input  wire logic           rsp_ready,
   output logic                rsp_is_pixel,
   output logic signed [15:0]  rsp_pixel_x,
   output logic signed [15:0]  rsp_pixel_y,
   output logic        [14:0]  rsp_advance_width,
   output logic                rsp_stopped,
   output logic                rsp_last
);

   glyph_type          done_ff, done_in;
   logic               valid_ff, valid_in;
   logic               is_pixel_ff, is_pixel_in;
   logic signed [15:0] x_ff, x_in;
   logic signed [15:0] y_ff, y_in;
   logic        [14:0] adv_ff, adv_in;
   logic               stopped_ff, stopped_in;
   logic               last_ff, last_in;

   glyph_type          remaining;
   glyph_type          sel_mask;
   logic               found;
   logic [ROW_W-1:0]   gy_sel;
   logic [COL_W-1:0]   gx_sel;
   logic               step;
   logic        [8:0]  x_off;
   logic        [8:0]  y_off;
   logic signed [17:0] x_sum;
   logic signed [17:0] y_sum;
   logic signed [16:0] adv_diff;
   logic        [14:0] adv_clamped;

   always_comb begin
      remaining = head_job.draw ? (head_job.rows & ~done_ff) : '0;
      found     = 1'b0;
      gy_sel    = '0;
      gx_sel    = '0;
      sel_mask  = '0;
      // scan from the far end so the earliest dot in row-major order wins
      for (int gy = GLYPH_ROWS - 1; gy >= 0; gy--) begin
         for (int gx = GLYPH_COLS - 1; gx >= 0; gx--) begin
            if (remaining[gy][GLYPH_COLS-1-gx]) begin
               found    = 1'b1;
               gy_sel   = ROW_W'(gy);
               gx_sel   = COL_W'(gx);
               sel_mask = '0;
               sel_mask[gy][GLYPH_COLS-1-gx] = 1'b1;
            end
         end
      end

      x_off = 9'(gx_sel) * 9'(cfg.pixel_scale);
      y_off = 9'(gy_sel) * 9'(cfg.pixel_scale);
      x_sum = {{2{head_job.cursor_start[15]}}, head_job.cursor_start} + {9'd0, x_off};
      y_sum = {{2{cfg.origin_y[15]}}, cfg.origin_y} + {9'd0, y_off};

      adv_diff = {head_job.cursor_after[15], head_job.cursor_after}
               - {cfg.origin_x[15], cfg.origin_x};
      if (adv_diff[16]) begin
         adv_clamped = '0;
      end else if (adv_diff[15]) begin
         adv_clamped = '1;
      end else begin
         adv_clamped = adv_diff[14:0];
      end

      step = head_valid && (!valid_ff || rsp_ready);
      pop  = step && !found;

      done_in     = done_ff;
      valid_in    = valid_ff;
      is_pixel_in = is_pixel_ff;
      x_in        = x_ff;
      y_in        = y_ff;
      adv_in      = adv_ff;
      stopped_in  = stopped_ff;
      last_in     = last_ff;
      if (step) begin
         valid_in = 1'b1;
         if (found) begin
            done_in     = done_ff | sel_mask;
            is_pixel_in = 1'b1;
            x_in        = sat16(x_sum);
            y_in        = sat16(y_sum);
            adv_in      = '0;
            stopped_in  = 1'b0;
            last_in     = 1'b0;
         end else begin
            done_in     = '0;
            is_pixel_in = 1'b0;
            x_in        = '0;
            y_in        = '0;
            adv_in      = adv_clamped;
            stopped_in  = head_job.stopped;
            last_in     = 1'b1;
         end
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         done_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      is_pixel_ff <= is_pixel_in;
      x_ff        <= x_in;
      y_ff        <= y_in;
      adv_ff      <= adv_in;
      stopped_ff  <= stopped_in;
      last_ff     <= last_in;
   end

   assign rsp_valid         = valid_ff;
   assign rsp_is_pixel      = is_pixel_ff;
   assign rsp_pixel_x       = x_ff;
   assign rsp_pixel_y       = y_ff;
   assign rsp_advance_width = adv_ff;
   assign rsp_stopped       = stopped_ff;
   assign rsp_last          = last_ff;

endmodule
`default_nettype wire

@@ rtl/bitmap_text_pixel_generator_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bitmap_text_pixel_generator_unit
// 5x7 bitmap text: one character in, its scaled lit dots and a status out.
//
//   channel  direction  handshake          payload
//   req      in         valid / ready      char_code, string_start
//   rsp      out        valid / ready      is_pixel, pixel_x, pixel_y,
//                                          advance_width, stopped, last
//   csr      in         apb, pready high   scale, origin x/y, clip right
//
// A drawn character with n lit dots gives n + 1 results, one per cycle while
// rsp is not stalled; a stopped or scale-zero character gives status only.
// The front takes a character every cycle while its 4-entry queue has room.
// Reset is synchronous: cursor, stop flag, queue and output valid clear, the
// registers return to their defaults. An output stall holds the dot walk,
// the queue fills, and then req_ready drops.
// ----------------------------------------------------------------------------
module bitmap_text_pixel_generator_unit import btpg_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic        [7:0]  req_char_code,
   input  wire logic               req_string_start,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic                    rsp_is_pixel,
   output logic signed [15:0]      rsp_pixel_x,
   output logic signed [15:0]      rsp_pixel_y,
   output logic        [14:0]      rsp_advance_width,
   output logic                    rsp_stopped,
   output logic                    rsp_last,
   input  wire logic               csr_psel,
   input  wire logic               csr_penable,
   input  wire logic               csr_pwrite,
   input  wire logic        [3:0]  csr_paddr,
   input  wire logic        [31:0] csr_pwdata,
   output logic             [31:0] csr_prdata,
   output logic                    csr_pready
);

   cfg_type    cfg_ff, cfg_in;
   logic [1:0] reg_index;
   logic       csr_write;

   logic       push_valid;
   job_type    push_job;
   logic       queue_full;
   logic       head_valid;
   job_type    head_job;
   logic       pop;

   assign csr_pready = 1'b1;
   assign reg_index  = csr_paddr[3:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (reg_index)
            REG_PIXEL_SCALE: cfg_in.pixel_scale = csr_pwdata[5:0];
            REG_ORIGIN_X:    cfg_in.origin_x    = csr_pwdata[15:0];
            REG_ORIGIN_Y:    cfg_in.origin_y    = csr_pwdata[15:0];
            REG_CLIP_RIGHT:  cfg_in.clip_right  = csr_pwdata[15:0];
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         REG_PIXEL_SCALE: csr_prdata = {26'd0, cfg_ff.pixel_scale};
         REG_ORIGIN_X:    csr_prdata = {16'd0, cfg_ff.origin_x};
         REG_ORIGIN_Y:    csr_prdata = {16'd0, cfg_ff.origin_y};
         REG_CLIP_RIGHT:  csr_prdata = {16'd0, cfg_ff.clip_right};
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pixel_scale <= 6'd1;
         cfg_ff.origin_x    <= '0;
         cfg_ff.origin_y    <= '0;
         cfg_ff.clip_right  <= 16'sh7fff;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   btpg_front u_front (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_char_code    (req_char_code),
      .req_string_start (req_string_start),
      .queue_full       (queue_full),
      .push_valid       (push_valid),
      .push_job         (push_job)
   );

   btpg_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_job   (push_job),
      .pop        (pop),
      .head_valid (head_valid),
      .head_job   (head_job),
      .full       (queue_full)
   );

   btpg_back u_back (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg_ff),
      .head_valid        (head_valid),
      .head_job          (head_job),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_is_pixel      (rsp_is_pixel),
      .rsp_pixel_x       (rsp_pixel_x),
      .rsp_pixel_y       (rsp_pixel_y),
      .rsp_advance_width (rsp_advance_width),
      .rsp_stopped       (rsp_stopped),
      .rsp_last          (rsp_last)
   );

endmodule
`default_nettype wire

@@ test/bitmap_text_pixel_generator_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_text_pixel_generator_unit_tb
// Self-checking bench for the 5x7 bitmap text pixel generator. A tracker
// class keeps its own cursor, stop flag and register copies. For every
// accepted character it lists the scaled lit dots and the closing status,
// and it compares each result transaction field by field against that list.
// Directed characters and settings come first: every glyph class, case
// folding, unknown codes, saturation, scale zero, clip stop and a moved
// origin. Random strings over random settings follow, with stalls on both
// channels.
// ----------------------------------------------------------------------------
module bitmap_text_pixel_generator_unit_tb;
   import btpg_pkg::*;

   localparam int QUIET_LIMIT = 500;

   typedef struct packed {
      logic               is_pixel;
      logic signed [15:0] pixel_x;
      logic signed [15:0] pixel_y;
      logic        [14:0] advance_width;
      logic               stopped;
      logic               last;
   } dot_result_type;

   class glyph_dot_tracker;
      int             dot_scale;
      int             origin_x;
      int             origin_y;
      int             clip_right;
      int             pen_x;
      bit             halted;
      int             mismatches;
      dot_result_type expected_dots[$];

      function new();
         dot_scale  = 1;
         origin_x   = 0;
         origin_y   = 0;
         clip_right = 32767;
         pen_x      = 0;
         halted     = 1'b0;
         mismatches = 0;
      endfunction

      function void apply_register(logic [1:0] idx, logic [31:0] value);
         case (idx)
            REG_PIXEL_SCALE: dot_scale  = int'(value[5:0]);
            REG_ORIGIN_X:    origin_x   = $signed(value[15:0]);
            REG_ORIGIN_Y:    origin_y   = $signed(value[15:0]);
            REG_CLIP_RIGHT:  clip_right = $signed(value[15:0]);
            default: ;
         endcase
      endfunction

      function int clamp16(int v);
         if (v > 32767) begin
            return 32767;
         end else if (v < -32768) begin
            return -32768;
         end
         return v;
      endfunction

      // seven rows of five dots, top row in the top bits, leftmost dot first
      function logic [34:0] glyph_rows(logic [7:0] code);
         logic [7:0] c;
         c = (code >= "a" && code <= "z") ? code - 8'd32 : code;
         case (c)
            "A": return {5'd14, 5'd17, 5'd17, 5'd31, 5'd17, 5'd17, 5'd17};
            "B": return {5'd30, 5'd17, 5'd17, 5'd30, 5'd17, 5'd17, 5'd30};
            "C": return {5'd14, 5'd17, 5'd16, 5'd16, 5'd16, 5'd17, 5'd14};
            "D": return {5'd30, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd30};
            "E": return {5'd31, 5'd16, 5'd16, 5'd30, 5'd16, 5'd16, 5'd31};
            "F": return {5'd31, 5'd16, 5'd16, 5'd30, 5'd16, 5'd16, 5'd16};
            "G": return {5'd14, 5'd17, 5'd16, 5'd23, 5'd17, 5'd17, 5'd14};
            "H": return {5'd17, 5'd17, 5'd17, 5'd31, 5'd17, 5'd17, 5'd17};
            "I": return {5'd31, 5'd4,  5'd4,  5'd4,  5'd4,  5'd4,  5'd31};
            "J": return {5'd7,  5'd2,  5'd2,  5'd2,  5'd2,  5'd18, 5'd12};
            "K": return {5'd17, 5'd18, 5'd20, 5'd24, 5'd20, 5'd18, 5'd17};
            "L": return {5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd31};
            "M": return {5'd17, 5'd27, 5'd21, 5'd21, 5'd17, 5'd17, 5'd17};
            "N": return {5'd17, 5'd25, 5'd21, 5'd19, 5'd17, 5'd17, 5'd17};
            "O": return {5'd14, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd14};
            "P": return {5'd30, 5'd17, 5'd17, 5'd30, 5'd16, 5'd16, 5'd16};
            "Q": return {5'd14, 5'd17, 5'd17, 5'd17, 5'd21, 5'd18, 5'd13};
            "R": return {5'd30, 5'd17, 5'd17, 5'd30, 5'd20, 5'd18, 5'd17};
            "S": return {5'd15, 5'd16, 5'd16, 5'd14, 5'd1,  5'd1,  5'd30};
            "T": return {5'd31, 5'd4,  5'd4,  5'd4,  5'd4,  5'd4,  5'd4};
            "U": return {5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd14};
            "V": return {5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd10, 5'd4};
            "W": return {5'd17, 5'd17, 5'd17, 5'd21, 5'd21, 5'd21, 5'd10};
            "X": return {5'd17, 5'd17, 5'd10, 5'd4,  5'd10, 5'd17, 5'd17};
            "Y": return {5'd17, 5'd17, 5'd10, 5'd4,  5'd4,  5'd4,  5'd4};
            "Z": return {5'd31, 5'd1,  5'd2,  5'd4,  5'd8,  5'd16, 5'd31};
            "0": return {5'd14, 5'd17, 5'd19, 5'd21, 5'd25, 5'd17, 5'd14};
            "1": return {5'd4,  5'd12, 5'd4,  5'd4,  5'd4,  5'd4,  5'd14};
            "2": return {5'd14, 5'd17, 5'd1,  5'd2,  5'd4,  5'd8,  5'd31};
            "3": return {5'd30, 5'd1,  5'd1,  5'd14, 5'd1,  5'd1,  5'd30};
            "4": return {5'd2,  5'd6,  5'd10, 5'd18, 5'd31, 5'd2,  5'd2};
            "5": return {5'd31, 5'd16, 5'd16, 5'd30, 5'd1,  5'd1,  5'd30};
            "6": return {5'd14, 5'd16, 5'd16, 5'd30, 5'd17, 5'd17, 5'd14};
            "7": return {5'd31, 5'd1,  5'd2,  5'd4,  5'd8,  5'd8,  5'd8};
            "8": return {5'd14, 5'd17, 5'd17, 5'd14, 5'd17, 5'd17, 5'd14};
            "9": return {5'd14, 5'd17, 5'd17, 5'd15, 5'd1,  5'd1,  5'd14};
            ":": return {5'd0,  5'd12, 5'd12, 5'd0,  5'd12, 5'd12, 5'd0};
            "-": return {5'd0,  5'd0,  5'd0,  5'd14, 5'd0,  5'd0,  5'd0};
            " ": return '0;
            // question mark for everything else
            default: return {5'd14, 5'd17, 5'd1, 5'd2, 5'd4, 5'd0, 5'd4};
         endcase
      endfunction

      function void accept_char(logic [7:0] code, bit start);
         logic [34:0]    rows;
         int             advance;
         dot_result_type r;
         if (start) begin
            pen_x  = origin_x;
            halted = 1'b0;
         end
         if (!halted) begin
            rows = glyph_rows(code);
            if (dot_scale > 0) begin
               for (int gy = 0; gy < 7; gy++) begin
                  for (int gx = 0; gx < 5; gx++) begin
                     if (rows[34 - 5 * gy - gx]) begin
                        r          = '0;
                        r.is_pixel = 1'b1;
                        r.pixel_x  = 16'(clamp16(pen_x + gx * dot_scale));
                        r.pixel_y  = 16'(clamp16(origin_y + gy * dot_scale));
                        expected_dots.push_back(r);
                     end
                  end
               end
            end
            pen_x = clamp16(pen_x + 6 * dot_scale);
            if (pen_x > clip_right - 8) begin
               halted = 1'b1;
            end
         end
         advance = pen_x - origin_x;
         if (advance < 0) begin
            advance = 0;
         end else if (advance > 32767) begin
            advance = 32767;
         end
         r               = '0;
         r.advance_width = 15'(advance);
         r.stopped       = halted;
         r.last          = 1'b1;
         expected_dots.push_back(r);
      endfunction

      function void check_result(dot_result_type got);
         dot_result_type want;
         if (expected_dots.size() == 0) begin
            $error("result with nothing pending: is_pixel %0d x %0d y %0d",
                   got.is_pixel, got.pixel_x, got.pixel_y);
            mismatches++;
         end else begin
            want = expected_dots.pop_front();
            if (got.is_pixel !== want.is_pixel) begin
               $error("is_pixel: expected %0d, got %0d", want.is_pixel, got.is_pixel);
               mismatches++;
            end
            if (got.pixel_x !== want.pixel_x) begin
               $error("pixel_x: expected %0d, got %0d", want.pixel_x, got.pixel_x);
               mismatches++;
            end
            if (got.pixel_y !== want.pixel_y) begin
               $error("pixel_y: expected %0d, got %0d", want.pixel_y, got.pixel_y);
               mismatches++;
            end
            if (got.advance_width !== want.advance_width) begin
               $error("advance_width: expected %0d, got %0d",
                      want.advance_width, got.advance_width);
               mismatches++;
            end
            if (got.stopped !== want.stopped) begin
               $error("stopped: expected %0d, got %0d", want.stopped, got.stopped);
               mismatches++;
            end
            if (got.last !== want.last) begin
               $error("last: expected %0d, got %0d", want.last, got.last);
               mismatches++;
            end
         end
      endfunction
   endclass

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic        [7:0]  req_char_code;
   logic               req_string_start;
   logic               rsp_valid;
   logic               rsp_ready;
   logic               rsp_is_pixel;
   logic signed [15:0] rsp_pixel_x;
   logic signed [15:0] rsp_pixel_y;
   logic        [14:0] rsp_advance_width;
   logic               rsp_stopped;
   logic               rsp_last;
   logic               csr_psel;
   logic               csr_penable;
   logic               csr_pwrite;
   logic        [3:0]  csr_paddr;
   logic        [31:0] csr_pwdata;
   logic        [31:0] csr_prdata;
   logic               csr_pready;

   glyph_dot_tracker tracker;
   bit               idle_on;
   int               ready_hold;
   int               quiet_cycles;

   bitmap_text_pixel_generator_unit dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_char_code     (req_char_code),
      .req_string_start  (req_string_start),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_is_pixel      (rsp_is_pixel),
      .rsp_pixel_x       (rsp_pixel_x),
      .rsp_pixel_y       (rsp_pixel_y),
      .rsp_advance_width (rsp_advance_width),
      .rsp_stopped       (rsp_stopped),
      .rsp_last          (rsp_last),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   always #6 clock = ~clock;

   // result side back-pressure in short bursts
   always @(posedge clock) begin
      if (ready_hold > 0) begin
         ready_hold = ready_hold - 1;
         rsp_ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
         ready_hold = $urandom_range(0, 5);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         tracker.check_result({rsp_is_pixel, rsp_pixel_x, rsp_pixel_y,
                               rsp_advance_width, rsp_stopped, rsp_last});
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles == QUIET_LIMIT) begin
         $display("bitmap_text_pixel_generator_unit: mismatch");
         $finish;
      end
   end

   task automatic csr_write(input logic [1:0] idx, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      tracker.apply_register(idx, value);
   endtask

   // upper data bits carry junk, the block keeps only the register width
   task automatic load_settings(input logic [5:0] scale, input logic [15:0] ox,
                                input logic [15:0] oy, input logic [15:0] clip);
      logic [31:0] junk;
      junk = $urandom();
      csr_write(REG_PIXEL_SCALE, {junk[31:6], scale});
      junk = $urandom();
      csr_write(REG_ORIGIN_X, {junk[31:16], ox});
      junk = $urandom();
      csr_write(REG_ORIGIN_Y, {junk[31:16], oy});
      junk = $urandom();
      csr_write(REG_CLIP_RIGHT, {junk[31:16], clip});
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_char(input logic [7:0] code, input bit start);
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_char_code    <= code;
      req_string_start <= start;
      do @(posedge clock); while (!req_ready);
      tracker.accept_char(code, start);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (tracker.expected_dots.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic logic [7:0] pick_code();
      string drawable = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789:- ";
      if ($urandom_range(0, 6) == 0) begin
         return 8'($urandom());
      end
      return drawable[$urandom_range(0, drawable.len() - 1)];
   endfunction

   // mostly proper strings, some carry on from the previous cursor
   task automatic random_strings(input int count);
      int left;
      int len;
      left = count;
      while (left > 0) begin
         len = $urandom_range(1, 12);
         for (int i = 0; i < len && left > 0; i++) begin
            send_char(pick_code(), (i == 0) ? ($urandom_range(0, 9) != 0)
                                            : ($urandom_range(0, 19) == 0));
            left--;
         end
      end
   endtask

   initial begin
      string       opening;
      logic [5:0]  scale;
      logic [15:0] ox;
      logic [15:0] oy;
      logic [15:0] clip;
      tracker          = new();
      clock            = 1'b0;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_char_code    = '0;
      req_string_start = 1'b0;
      rsp_ready        = 1'b0;
      csr_psel         = 1'b0;
      csr_penable      = 1'b0;
      csr_pwrite       = 1'b0;
      csr_paddr        = '0;
      csr_pwdata       = '0;
      idle_on          = 1'b1;
      ready_hold       = 0;
      quiet_cycles     = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // defaults after reset: glyph classes, case folding, unknown codes
      opening = "AaZz09:- ?@[`{MWQ";
      for (int i = 0; i < opening.len(); i++) begin
         send_char(opening[i], i == 0);
      end
      send_char(8'h00, 1'b0);
      send_char(8'hff, 1'b0);
      send_char(8'h80, 1'b1);
      send_char(8'h7f, 1'b0);
      wait_drained();

      // saturation at the top corner, clip crossing, then stopped characters
      load_settings(6'd63, 16'h7fbc, 16'h7fbc, 16'h7fff);
      send_char("W", 1'b1);
      send_char("H", 1'b0);
      send_char("8", 1'b0);
      send_char("E", 1'b1);
      wait_drained();

      // scale zero: no dots, no movement, clip test still made
      load_settings(6'd0, 16'h0000, 16'h0000, 16'h7fff);
      send_char("A", 1'b1);
      send_char("B", 1'b0);
      wait_drained();
      load_settings(6'd0, 16'h0000, 16'h8000, 16'h8000);
      send_char("C", 1'b1);
      send_char("D", 1'b0);
      wait_drained();

      // origin moved inside a string gives a negative advance, clamped to zero
      load_settings(6'd2, 16'h8000, 16'h8000, 16'h7fff);
      send_char("K", 1'b1);
      send_char("4", 1'b0);
      wait_drained();
      load_settings(6'd2, 16'd1000, 16'h7fff, 16'h7fff);
      send_char("R", 1'b0);
      send_char("S", 1'b0);
      wait_drained();

      for (int p = 0; p < 8; p++) begin
         idle_on = (p < 7) && ($urandom_range(0, 3) != 0);
         case ($urandom_range(0, 5))
            0:       scale = 6'd63;
            1:       scale = 6'($urandom_range(1, 63));
            default: scale = 6'($urandom_range(1, 4));
         endcase
         ox = ($urandom_range(0, 4) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 800) - 400);
         oy = ($urandom_range(0, 4) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 800) - 400);
         clip = ($urandom_range(0, 3) == 0) ? 16'($urandom())
                                            : ox + 16'($urandom_range(0, 1500));
         load_settings(scale, ox, oy, clip);
         random_strings(42);
         wait_drained();
      end

      repeat (30) @(posedge clock);
      if (tracker.mismatches == 0 && tracker.expected_dots.size() == 0) begin
         $display("bitmap_text_pixel_generator_unit: match");
      end else begin
         $display("bitmap_text_pixel_generator_unit: mismatch");
      end
      $finish;
   end

endmodule

@@ sim.f @@
rtl/btpg_pkg.sv
rtl/btpg_front.sv
rtl/btpg_queue.sv
rtl/btpg_back.sv
rtl/bitmap_text_pixel_generator_unit.sv
test/bitmap_text_pixel_generator_unit_tb.sv
